[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define GLZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GLZ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/glz_pkg.sv]
// ----------------------------------------------------------------------------
// glz_pkg
// shared types, codes and constants of the gif lzw decoder
// ----------------------------------------------------------------------------
package glz_pkg;

  localparam int TABLE_SIZE_DEF = 4096;
  localparam int SYM_W          = 8;
  localparam int BUF_W          = 24;
  localparam int CNT_W          = 5;
  localparam int CW_W           = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam logic [CW_W-1:0] MCS_RESET = 4'd8;
  localparam logic [CW_W-1:0] MCS_MIN   = 4'd1;
  localparam logic [CW_W-1:0] MCS_MAX   = 4'd8;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_PIXEL  = 3'd0,
    ST_NEED   = 3'd1,
    ST_END    = 3'd2,
    ST_ERROR  = 3'd3,
    ST_ACCEPT = 3'd4,
    ST_REJECT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FIN_RUN = 2'd0,
    FIN_END = 2'd1,
    FIN_ERR = 2'd2
  } fin_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_ADD,
    S_WALK,
    S_POP,
    S_EMIT
  } eng_state_t;

  typedef struct packed {
    kind_t            kind;
    logic [SYM_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [SYM_W-1:0] pixel;
    status_t          status;
  } result_t;

  // minimum code size limited to the legal range
  function automatic logic [CW_W-1:0] clamp_mcs(input logic [CW_W-1:0] v);
    logic [CW_W-1:0] r;
    r = v;
    if (v < MCS_MIN) r = MCS_MIN;
    if (v > MCS_MAX) r = MCS_MAX;
    return r;
  endfunction

endpackage

[hw/rtl/glz_front.sv]
// ----------------------------------------------------------------------------
// glz_front
// input side: classifies incoming words and holds them in a short queue
// ----------------------------------------------------------------------------
module glz_front
  import glz_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       in_kind,
  input  logic [SYM_W-1:0] in_data_byte,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_take
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          wr, rd;
  cmd_t          cls;

  // decode the raw kind field into a command class
  always_comb begin
    case (in_kind)
      KIND_BYTE:    cls.kind = KIND_BYTE;
      KIND_PIXEL:   cls.kind = KIND_PIXEL;
      KIND_RESTART: cls.kind = KIND_RESTART;
      default:      cls.kind = KIND_UNUSED;
    endcase
    cls.data = in_data_byte;
  end

  assign full      = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule

[hw/rtl/glz_outq.sv]
// ----------------------------------------------------------------------------
// glz_outq
// result side queue between the decode engine and the output ports
// ----------------------------------------------------------------------------
module glz_outq
  import glz_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  result_t       q_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          wr, rd;

  assign res_full = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head     = q_r[rp_r];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule

[hw/rtl/glz_engine.sv]
// ----------------------------------------------------------------------------
// glz_engine
// back end: bit unpacking, dictionary update, chain walk and pixel pop
// ----------------------------------------------------------------------------
module glz_engine
  import glz_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [CW_W-1:0] cfg_mcs,
  input  logic            cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_take,
  input  logic            res_full,
  output logic            res_push,
  output result_t         res
);

  `include "assert_macros.svh"

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = IW + 1;

  // dictionary and string stack
  logic [IW-1:0]    dict_prefix [TABLE_SIZE];
  logic [SYM_W-1:0] dict_first  [TABLE_SIZE];
  logic [SYM_W-1:0] dict_last   [TABLE_SIZE];
  logic [IW-1:0]    dict_len    [TABLE_SIZE];
  logic [SYM_W-1:0] stack_mem   [TABLE_SIZE];

  eng_state_t       state_r, state_nxt;
  logic [CW_W-1:0]  active_r, active_nxt;
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW_W-1:0]  width_r, width_nxt;
  logic [CW-1:0]    nf_r, nf_nxt;
  logic [IW-1:0]    prev_r, prev_nxt;
  logic             pv_r, pv_nxt;
  logic [CW-1:0]    pend_r, pend_nxt;
  fin_t             fin_r, fin_nxt;
  logic [IW-1:0]    code_r, code_nxt;
  logic [IW-1:0]    len_r, len_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [SYM_W-1:0] cur_last_r, cur_last_nxt;
  logic [IW-1:0]    cur_prefix_r, cur_prefix_nxt;
  logic             wfirst_r, wfirst_nxt;
  logic [IW-1:0]    addr_a_r;

  logic [IW-1:0]    rd_prefix_a, rd_prefix_b, rd_len_a, rd_len_b;
  logic [SYM_W-1:0] rd_first_a, rd_first_b, rd_last_a, rd_last_b, stk_q;
  logic [IW-1:0]    rd_addr_a, rd_addr_b, stk_raddr;
  logic             dict_we, stk_we;
  logic [SYM_W-1:0] new_last, src_last;
  logic [IW-1:0]    src_prefix;

  logic [CW-1:0]    clear_w;
  logic [IW-1:0]    code_mask, code_x;
  logic [CW-1:0]    code_x13, code_r13, nf_inc;
  logic             need_bits, is_clear, is_end, is_err;
  logic             root_a, root_b, add_ok, is_new, grow, last_step;
  logic [SYM_W-1:0] a_first, b_first, b_last;
  logic [IW-1:0]    a_len, b_len, walk_len;
  logic             take;

  // decoded code fields
  assign clear_w   = CW'(1) << active_r;
  assign code_mask = ~({IW{1'b1}} << width_r);
  assign code_x    = buf_r[IW-1:0] & code_mask;
  assign code_x13  = {1'b0, code_x};
  assign code_r13  = {1'b0, code_r};
  assign need_bits = cnt_r < {1'b0, width_r};
  assign is_clear  = (code_x13 == clear_w);
  assign is_end    = (code_x13 == clear_w + CW'(1)) || (code_x13 > nf_r);
  assign is_err    = (code_x13 == nf_r) && !pv_r;
  assign take      = (state_r == S_IDLE) && cmd_valid && !res_full;
  assign cmd_take  = take;

  // roots are implied and never stored
  assign root_a  = {1'b0, addr_a_r} < clear_w;
  assign root_b  = code_r13 < clear_w;
  assign a_first = root_a ? addr_a_r[SYM_W-1:0] : rd_first_a;
  assign a_len   = root_a ? IW'(1) : rd_len_a;
  assign b_first = root_b ? code_r[SYM_W-1:0] : rd_first_b;
  assign b_last  = root_b ? code_r[SYM_W-1:0] : rd_last_b;
  assign b_len   = root_b ? IW'(1) : rd_len_b;

  assign add_ok   = pv_r && (nf_r < CW'(TABLE_SIZE));
  assign is_new   = (code_r13 == nf_r);
  assign new_last = is_new ? a_first : b_first;
  assign nf_inc   = nf_r + CW'(1);
  assign grow     = add_ok && (nf_inc >= (CW'(1) << width_r)) &&
                    (nf_inc < CW'(TABLE_SIZE)) && (width_r < CW_W'(IW));
  assign walk_len = is_new ? (a_len + IW'(1)) : b_len;

  // walk source: first step from saved entry, then from memory
  assign src_last   = wfirst_r ? cur_last_r :
                      (root_a ? addr_a_r[SYM_W-1:0] : rd_last_a);
  assign src_prefix = wfirst_r ? cur_prefix_r : rd_prefix_a;
  assign last_step  = (idx_r == len_r - IW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take && cmd.kind == KIND_PIXEL && fin_r == FIN_RUN) begin
          state_nxt = (pend_r != '0) ? S_POP : S_DEC;
        end
      end
      S_DEC: begin
        if (need_bits) state_nxt = S_IDLE;
        else if (is_clear) state_nxt = S_DEC;
        else if (is_end || is_err) state_nxt = S_IDLE;
        else state_nxt = S_ADD;
      end
      S_ADD:  state_nxt = S_WALK;
      S_WALK: if (last_step) state_nxt = S_POP;
      S_POP:  state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    active_nxt     = active_r;
    buf_nxt        = buf_r;
    cnt_nxt        = cnt_r;
    width_nxt      = width_r;
    nf_nxt         = nf_r;
    prev_nxt       = prev_r;
    pv_nxt         = pv_r;
    pend_nxt       = pend_r;
    fin_nxt        = fin_r;
    code_nxt       = code_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    cur_last_nxt   = cur_last_r;
    cur_prefix_nxt = cur_prefix_r;
    wfirst_nxt     = wfirst_r;
    res_push       = 1'b0;
    res.pixel      = '0;
    res.status     = ST_REJECT;
    dict_we        = 1'b0;
    stk_we         = 1'b0;
    rd_addr_a      = prev_r;
    rd_addr_b      = code_r;
    stk_raddr      = IW'(pend_r - CW'(1));
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (cmd.kind)
            KIND_BYTE: begin
              res_push = 1'b1;
              if (fin_r != FIN_RUN || cnt_r > CNT_W'(16)) begin
                res.status = ST_REJECT;
              end else begin
                buf_nxt    = buf_r | (BUF_W'(cmd.data) << cnt_r);
                cnt_nxt    = cnt_r + CNT_W'(8);
                res.status = ST_ACCEPT;
              end
            end
            KIND_PIXEL: begin
              if (fin_r == FIN_END) begin
                res_push   = 1'b1;
                res.status = ST_END;
              end else if (fin_r == FIN_ERR) begin
                res_push   = 1'b1;
                res.status = ST_ERROR;
              end
            end
            KIND_RESTART: begin
              active_nxt = clamp_mcs(cfg_mcs);
              nf_nxt     = (CW'(1) << clamp_mcs(cfg_mcs)) + CW'(2);
              width_nxt  = clamp_mcs(cfg_mcs) + CW_W'(1);
              pv_nxt     = 1'b0;
              prev_nxt   = '0;
              buf_nxt    = '0;
              cnt_nxt    = '0;
              pend_nxt   = '0;
              fin_nxt    = FIN_RUN;
              res_push   = 1'b1;
              res.status = ST_NEED;
            end
            default: begin
              res_push   = 1'b1;
              res.status = ST_REJECT;
            end
          endcase
        end
      end
      S_DEC: begin
        rd_addr_b = code_x;
        if (need_bits) begin
          res_push   = 1'b1;
          res.status = ST_NEED;
        end else begin
          buf_nxt = buf_r >> width_r;
          cnt_nxt = cnt_r - {1'b0, width_r};
          if (is_clear) begin
            nf_nxt    = clear_w + CW'(2);
            width_nxt = active_r + CW_W'(1);
            pv_nxt    = 1'b0;
            prev_nxt  = '0;
          end else if (is_end) begin
            fin_nxt    = FIN_END;
            res_push   = 1'b1;
            res.status = ST_END;
          end else if (is_err) begin
            fin_nxt    = FIN_ERR;
            res_push   = 1'b1;
            res.status = ST_ERROR;
          end else begin
            code_nxt = code_x;
          end
        end
      end
      S_ADD: begin
        if (add_ok) begin
          dict_we = 1'b1;
          nf_nxt  = nf_inc;
          if (grow) width_nxt = width_r + CW_W'(1);
        end
        cur_last_nxt   = is_new ? new_last : b_last;
        cur_prefix_nxt = is_new ? prev_r : rd_prefix_b;
        len_nxt        = (walk_len == '0) ? IW'(1) : walk_len;
        idx_nxt        = '0;
        wfirst_nxt     = 1'b1;
        prev_nxt       = code_r;
        pv_nxt         = 1'b1;
      end
      S_WALK: begin
        stk_we     = 1'b1;
        rd_addr_a  = src_prefix;
        wfirst_nxt = 1'b0;
        idx_nxt    = idx_r + IW'(1);
        if (last_step) pend_nxt = {1'b0, len_r};
      end
      S_POP: begin
      end
      S_EMIT: begin
        res_push   = 1'b1;
        res.status = ST_PIXEL;
        res.pixel  = stk_q;
        pend_nxt   = pend_r - CW'(1);
      end
      default: begin
      end
    endcase
  end

  // dictionary: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (dict_we) begin
      dict_prefix[nf_r[IW-1:0]] <= prev_r;
      dict_first[nf_r[IW-1:0]]  <= a_first;
      dict_last[nf_r[IW-1:0]]   <= new_last;
      dict_len[nf_r[IW-1:0]]    <= a_len + IW'(1);
    end
    rd_prefix_a <= dict_prefix[rd_addr_a];
    rd_first_a  <= dict_first[rd_addr_a];
    rd_last_a   <= dict_last[rd_addr_a];
    rd_len_a    <= dict_len[rd_addr_a];
    rd_prefix_b <= dict_prefix[rd_addr_b];
    rd_first_b  <= dict_first[rd_addr_b];
    rd_last_b   <= dict_last[rd_addr_b];
    rd_len_b    <= dict_len[rd_addr_b];
    addr_a_r    <= rd_addr_a;
  end

  // string stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[idx_r] <= src_last;
    end
    stk_q <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= clamp_mcs(MCS_RESET);
      buf_r    <= '0;
      cnt_r    <= '0;
      width_r  <= clamp_mcs(MCS_RESET) + CW_W'(1);
      nf_r     <= (CW'(1) << clamp_mcs(MCS_RESET)) + CW'(2);
      prev_r   <= '0;
      pv_r     <= 1'b0;
      pend_r   <= '0;
      fin_r    <= FIN_RUN;
      len_r    <= IW'(1);
      idx_r    <= '0;
      wfirst_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      buf_r    <= buf_nxt;
      cnt_r    <= cnt_nxt;
      width_r  <= width_nxt;
      nf_r     <= nf_nxt;
      prev_r   <= prev_nxt;
      pv_r     <= pv_nxt;
      pend_r   <= pend_nxt;
      fin_r    <= fin_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      wfirst_r <= wfirst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    cur_last_r   <= cur_last_nxt;
    cur_prefix_r <= cur_prefix_nxt;
  end

  `GLZ_ASSERT(a_cnt_range, cnt_r <= CNT_W'(BUF_W), "bit count above buffer size")
  `GLZ_ASSERT_IMPL(a_push_room, res_push, !res_full, "result pushed into a full queue")
  `GLZ_ASSERT_IMPL(a_walk_idx, state_r == S_WALK, idx_r < len_r, "walk index past string")
  `GLZ_ASSERT_IMPL(a_pop_pend, state_r == S_POP, pend_r != '0, "pop with empty stack")

endmodule

[hw/rtl/gif_lzw_decoder_unit.sv]
// a byte, restart or finished-state word is answered straight from idle; a pixel
// from the stack passes the pop and emit states; a new code first passes decode, add
// and a chain walk of one step per symbol of its string (one dictionary read port),
// and each clear code repeats decode before the next code is read
// the engine holds one word at a time and takes no new word until it is back in idle
// reset (rst_n low, synchronous): queues empty, min code size 8, dictionary not cleared
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit
// gif lzw decoder with queue-style ports: bytes in, palette indices out on request
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit
  import glz_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  // input word channel
  input  logic             push,
  output logic             full,
  input  logic [1:0]       in_kind,
  input  logic [SYM_W-1:0] in_data_byte,
  // result word channel
  output logic             empty,
  input  logic             pop,
  output logic [SYM_W-1:0] out_pixel_index,
  output logic [2:0]       out_status,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [CW_W-1:0]  cfg_min_code_size
);

  // min code size register, latched into the engine on restart
  logic [CW_W-1:0] mcs_r;

  cmd_t    cmd;
  logic    cmd_valid, cmd_take;
  result_t res, head;
  logic    res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcs_r <= MCS_RESET;
    end else if (cfg_wr_en) begin
      mcs_r <= cfg_min_code_size;
    end
  end

  // front end: classify and buffer incoming words
  glz_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // back end: code unpacking, dictionary, chain walk, stack pops
  glz_engine #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_mcs   (mcs_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue toward the consumer
  glz_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign out_pixel_index = head.pixel;
  assign out_status      = head.status;

endmodule
